// ----- rtl/pps_pkg.sv -----
// Shared types and constants for the precedence parser symbol stack.
package pps_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = 6;
  localparam int OP_W        = 3;
  localparam int KIND_W      = 5;
  localparam int TYPE_W      = 3;
  localparam int ENTRY_W     = KIND_W + TYPE_W;

  // Kinds below the reduce marker are terminals.
  localparam logic [KIND_W-1:0] REDUCE_MARK = 5'd19;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_POPN   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd5;

  // Topmost terminal among entries 0..i, kept for every stack level.
  typedef struct packed {
    logic              found;
    logic [KIND_W-1:0] kind;
    logic [TYPE_W-1:0] dtype;
    logic [IDX_W-1:0]  idx;
  } term_info_t;

  localparam int TERM_W = $bits(term_info_t);

  typedef struct packed {
    logic [CNT_W-1:0]  pop_amount;
    logic [TYPE_W-1:0] data_type;
    logic [KIND_W-1:0] symbol_kind;
    logic [OP_W-1:0]   operation;
  } request_t;

  typedef struct packed {
    logic [CNT_W-1:0]  fill_count;
    logic [TYPE_W-1:0] top_term_type;
    logic [KIND_W-1:0] top_term_kind;
    logic              term_found;
    logic              ok;
  } result_t;

endpackage

// ----- rtl/pps_ram.sv -----
// Simple dual-port RAM: one write port, one read port, registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pps_ctrl.sv -----
// Stack sequencer: decodes requests, drives both RAMs, walks the insert shift.
module pps_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  pps_pkg::request_t               req,
  output logic                            res_valid,
  input  logic                            res_ready,
  output pps_pkg::result_t                res,
  output logic                            ent_we,
  output logic [pps_pkg::IDX_W-1:0]       ent_waddr,
  output logic [pps_pkg::ENTRY_W-1:0]     ent_wdata,
  output logic [pps_pkg::IDX_W-1:0]       ent_raddr,
  input  logic [pps_pkg::ENTRY_W-1:0]     ent_rdata,
  output logic                            term_we,
  output logic [pps_pkg::IDX_W-1:0]       term_waddr,
  output logic [pps_pkg::TERM_W-1:0]      term_wdata,
  output logic [pps_pkg::IDX_W-1:0]       term_raddr,
  input  logic [pps_pkg::TERM_W-1:0]      term_rdata
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_POPWAIT = 3'd1;
  localparam logic [2:0] S_SHRD    = 3'd2;
  localparam logic [2:0] S_SHWR    = 3'd3;
  localparam logic [2:0] S_INSW    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]                     state;
  logic [pps_pkg::CNT_W-1:0]      count;
  pps_pkg::term_info_t            top;
  logic                           ok;
  logic [pps_pkg::IDX_W-1:0]      pos;
  logic [pps_pkg::IDX_W-1:0]      j;
  pps_pkg::term_info_t            ins_info;
  logic [pps_pkg::ENTRY_W-1:0]    ins_entry;

  logic                           accept;
  logic                           not_full;
  logic                           term_in;
  logic [pps_pkg::IDX_W-1:0]      ins_pos;
  logic [pps_pkg::IDX_W-1:0]      j_dec;
  pps_pkg::term_info_t            push_info;
  pps_pkg::term_info_t            ins_info_c;
  logic [pps_pkg::ENTRY_W-1:0]    new_entry;
  logic                           pop_ok;
  logic [pps_pkg::CNT_W-1:0]      pop_cnt;

  assign accept    = (state == S_IDLE) && req_valid;
  assign req_ready = (state == S_IDLE);
  assign not_full  = count < pps_pkg::CNT_W'(pps_pkg::STACK_DEPTH);
  assign term_in   = req.symbol_kind < pps_pkg::REDUCE_MARK;
  assign new_entry = {req.data_type, req.symbol_kind};
  assign ins_pos   = top.idx + pps_pkg::IDX_W'(1);
  assign j_dec     = j - pps_pkg::IDX_W'(1);

  always_comb begin
    push_info = top;
    if (term_in) begin
      push_info = '{found: 1'b1, kind: req.symbol_kind, dtype: req.data_type,
                    idx: count[pps_pkg::IDX_W-1:0]};
    end
    ins_info_c = top;
    if (term_in) begin
      ins_info_c = '{found: 1'b1, kind: req.symbol_kind, dtype: req.data_type,
                     idx: ins_pos};
    end
  end

  always_comb begin
    if (req.operation == pps_pkg::OP_POP) begin
      pop_ok  = (count != '0);
      pop_cnt = count - pps_pkg::CNT_W'(1);
    end else begin
      pop_ok  = (req.pop_amount <= count);
      pop_cnt = count - req.pop_amount;
    end
  end

  // RAM ports
  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = count[pps_pkg::IDX_W-1:0];
    ent_wdata  = new_entry;
    term_we    = 1'b0;
    term_wdata = push_info;
    case (state)
      S_IDLE: begin
        ent_we  = accept && (req.operation == pps_pkg::OP_PUSH) && not_full;
        term_we = ent_we;
      end
      S_SHWR: begin
        ent_we     = 1'b1;
        ent_waddr  = j;
        ent_wdata  = ent_rdata;
        term_we    = 1'b1;
        term_wdata = ins_info;
      end
      S_INSW: begin
        ent_we     = 1'b1;
        ent_waddr  = pos;
        ent_wdata  = ins_entry;
        term_we    = 1'b1;
        term_wdata = ins_info;
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
    term_waddr = ent_waddr;
  end

  assign ent_raddr  = j_dec;
  assign term_raddr = pop_cnt[pps_pkg::IDX_W-1:0] - pps_pkg::IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      top   <= '0;
      ok    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DONE;
            ok    <= 1'b0;
            case (req.operation)
              pps_pkg::OP_PUSH: begin
                if (not_full) begin
                  count <= count + pps_pkg::CNT_W'(1);
                  top   <= push_info;
                  ok    <= 1'b1;
                end
              end
              pps_pkg::OP_POP, pps_pkg::OP_POPN: begin
                if (pop_ok) begin
                  ok    <= 1'b1;
                  count <= pop_cnt;
                  if (pop_cnt == '0) begin
                    top <= '0;
                  end else if (pop_cnt != count) begin
                    state <= S_POPWAIT;
                  end
                end
              end
              pps_pkg::OP_CLEAR: begin
                count <= '0;
                top   <= '0;
                ok    <= 1'b1;
              end
              pps_pkg::OP_INSERT: begin
                if (top.found && not_full) begin
                  pos       <= ins_pos;
                  j         <= count[pps_pkg::IDX_W-1:0];
                  ins_info  <= ins_info_c;
                  ins_entry <= new_entry;
                  state     <= (count[pps_pkg::IDX_W-1:0] > ins_pos) ? S_SHRD : S_INSW;
                end
              end
              pps_pkg::OP_QUERY: begin
                ok <= top.found;
              end
              default: begin
                ok <= 1'b0;
              end
            endcase
          end
        end
        S_POPWAIT: begin
          top   <= pps_pkg::term_info_t'(term_rdata);
          state <= S_DONE;
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          j     <= j_dec;
          state <= (j_dec > pos) ? S_SHRD : S_INSW;
        end
        S_INSW: begin
          count <= count + pps_pkg::CNT_W'(1);
          top   <= ins_info;
          ok    <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state == S_DONE);
  assign res = '{fill_count: count, top_term_type: top.dtype, top_term_kind: top.kind,
                 term_found: top.found, ok: ok};

endmodule

// ----- rtl/precedence_parser_symbol_stack.sv -----
// Top level of the precedence parser symbol stack: RAMs, sequencer, output register.
// Use: one item on the slave stream is one stack request; every request
// returns exactly one result item on the master stream, in order.
// s_tdata (low bit up): operation[2:0], symbol_kind[7:3], data_type[10:8],
// pop_amount[16:11], zero fill to 24 bits.
// m_tdata (low bit up): ok[0], term_found[1], top_term_kind[6:2],
// top_term_type[9:7], fill_count[15:10].
// Entries live in one RAM; a second RAM keeps, for every level, the topmost
// terminal at or below it, so the top terminal is always held in a register
// and a pop needs only one RAM read.
// From accept to the result: push, clear, query, failed requests, pop n of
// zero and pops that empty the stack go straight to the result; other pops
// and pop n first read the term RAM; insert first shifts every entry above
// the top terminal up, a read and a write per shift, then writes the new entry.
// One item is in work at a time: s_tready is high only while the sequencer
// is idle, so no new item is taken until the last is through. A result waits in
// the output register while the receiver stalls; the next item is still
// accepted and worked, and its result is held in the sequencer until the
// register frees. Reset (rst, synchronous) empties the stack and drops any
// pending result; RAM contents are not cleared and are never read unwritten.
module precedence_parser_symbol_stack (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // operation, symbol_kind, data_type, pop_amount
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // ok, term_found, top_term_kind, top_term_type, fill_count
);

  pps_pkg::request_t                 req;
  pps_pkg::result_t                  res;
  logic                              res_valid;
  logic                              res_ready;

  logic                              ent_we;
  logic [pps_pkg::IDX_W-1:0]         ent_waddr;
  logic [pps_pkg::ENTRY_W-1:0]       ent_wdata;
  logic [pps_pkg::IDX_W-1:0]         ent_raddr;
  logic [pps_pkg::ENTRY_W-1:0]       ent_rdata;
  logic                              term_we;
  logic [pps_pkg::IDX_W-1:0]         term_waddr;
  logic [pps_pkg::TERM_W-1:0]        term_wdata;
  logic [pps_pkg::IDX_W-1:0]         term_raddr;
  logic [pps_pkg::TERM_W-1:0]        term_rdata;

  assign req = pps_pkg::request_t'(s_tdata[$bits(pps_pkg::request_t)-1:0]);

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ent_we     (ent_we),
    .ent_waddr  (ent_waddr),
    .ent_wdata  (ent_wdata),
    .ent_raddr  (ent_raddr),
    .ent_rdata  (ent_rdata),
    .term_we    (term_we),
    .term_waddr (term_waddr),
    .term_wdata (term_wdata),
    .term_raddr (term_raddr),
    .term_rdata (term_rdata)
  );

  // Stack entries: kind in the low bits, type above.
  pps_ram #(
    .WIDTH (pps_pkg::ENTRY_W),
    .DEPTH (pps_pkg::STACK_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Per-level topmost terminal record.
  pps_ram #(
    .WIDTH (pps_pkg::TERM_W),
    .DEPTH (pps_pkg::STACK_DEPTH)
  ) u_term_ram (
    .clk   (clk),
    .we    (term_we),
    .waddr (term_waddr),
    .wdata (term_wdata),
    .raddr (term_raddr),
    .rdata (term_rdata)
  );

  // Output register: refills in the same cycle the receiver takes an item.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res;
    end
  end

endmodule

// ----- sim/precedence_parser_symbol_stack_tb.sv -----
// Self-checking testbench for the precedence parser symbol stack.
module precedence_parser_symbol_stack_tb;

  // Stack model plus the queue of results still owed by the block.
  class symbol_stack_scoreboard;
    logic [pps_pkg::ENTRY_W-1:0] entries [pps_pkg::STACK_DEPTH];
    int unsigned                 fill;
    pps_pkg::result_t            owed_q [$];
    int                          error_count;

    function new();
      fill        = 0;
      error_count = 0;
    endfunction

    // Index of the topmost terminal, -1 if none.
    function int top_term_index();
      for (int i = int'(fill) - 1; i >= 0; i--) begin
        if (entries[i][pps_pkg::KIND_W-1:0] < pps_pkg::REDUCE_MARK) return i;
      end
      return -1;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted request to the model, queue the result it owes.
    function void note_request(pps_pkg::request_t req);
      pps_pkg::result_t res;
      int               t;
      bit               done;
      done = 1'b0;
      case (req.operation)
        pps_pkg::OP_PUSH: begin
          if (fill < pps_pkg::STACK_DEPTH) begin
            entries[fill] = {req.data_type, req.symbol_kind};
            fill++;
            done = 1'b1;
          end
        end
        pps_pkg::OP_POP: begin
          if (fill > 0) begin
            fill--;
            done = 1'b1;
          end
        end
        pps_pkg::OP_POPN: begin
          if (req.pop_amount <= fill) begin
            fill -= req.pop_amount;
            done = 1'b1;
          end
        end
        pps_pkg::OP_CLEAR: begin
          fill = 0;
          done = 1'b1;
        end
        pps_pkg::OP_INSERT: begin
          t = top_term_index();
          if (t >= 0 && fill < pps_pkg::STACK_DEPTH) begin
            // shift everything above the terminal up by one
            for (int j = int'(fill); j > t + 1; j--) entries[j] = entries[j-1];
            entries[t+1] = {req.data_type, req.symbol_kind};
            fill++;
            done = 1'b1;
          end
        end
        pps_pkg::OP_QUERY: done = (top_term_index() >= 0);
        default:  done = 1'b0;
      endcase
      t   = top_term_index();
      res = '0;
      res.ok = done;
      if (t >= 0) begin
        res.term_found    = 1'b1;
        res.top_term_kind = entries[t][pps_pkg::KIND_W-1:0];
        res.top_term_type = entries[t][pps_pkg::ENTRY_W-1:pps_pkg::KIND_W];
      end
      res.fill_count = pps_pkg::CNT_W'(fill);
      owed_q.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
    endtask

    task check_result(pps_pkg::result_t got);
      pps_pkg::result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result with no request pending", got, 0);
        return;
      end
      want = owed_q.pop_front();
      if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
      if (got.term_found !== want.term_found)
        report_mismatch("term_found", got.term_found, want.term_found);
      if (got.top_term_kind !== want.top_term_kind)
        report_mismatch("top_term_kind", got.top_term_kind, want.top_term_kind);
      if (got.top_term_type !== want.top_term_type)
        report_mismatch("top_term_type", got.top_term_type, want.top_term_type);
      if (got.fill_count !== want.fill_count)
        report_mismatch("fill_count", got.fill_count, want.fill_count);
    endtask
  endclass

  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the block
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 80;   // covers the deepest insert shift

  // Operation codes the block does not define.
  localparam logic [pps_pkg::OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [pps_pkg::OP_W-1:0] OP_UNUSED_B = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;       // operation, symbol_kind, data_type, pop_amount
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;             // ok, term_found, top_term_kind, top_term_type, fill_count

  symbol_stack_scoreboard sb;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase         = 0;   // 0: slow receiver, 1: slow sender, 2: no idling
  int sent          = 0;

  precedence_parser_symbol_stack u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

  // Result side: every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(pps_pkg::result_t'(m_tdata));
  end

  // Receiver backpressure. Once, at the start of the no-idle phase, it
  // holds off long enough that the output register and the sequencer both
  // fill and s_tready drops while the sender keeps offering.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request, wait for the handshake, log it in the model.
  // Called at a falling edge; returns at a falling edge with s_tvalid still
  // high, so back-to-back items keep valid up.
  task send_request(input pps_pkg::request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, req};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req);
    sent++;
    @(negedge clk);
  endtask

  task issue(input logic [pps_pkg::OP_W-1:0] op, input int kind, input int dtype,
             input int amount);
    pps_pkg::request_t req;
    req.operation   = op;
    req.symbol_kind = pps_pkg::KIND_W'(kind);
    req.data_type   = pps_pkg::TYPE_W'(dtype);
    req.pop_amount  = pps_pkg::CNT_W'(amount);
    send_request(req);
  endtask

  // Terminal kinds sit below the reduce marker; the rest of the 5-bit range
  // (marker, expression and unnamed codes) are non-terminals.
  function int pick_kind(input bit terminal);
    if (terminal) return $urandom_range(int'(pps_pkg::REDUCE_MARK) - 1);
    return $urandom_range(31, int'(pps_pkg::REDUCE_MARK));
  endfunction

  function int pick_type();
    return $urandom_range(7);
  endfunction

  // One short, mostly well-formed burst of parser-like requests.
  task random_sequence();
    int          sel;
    int          n;
    int          amt;
    logic [31:0] noise;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // fill to the top, then push / insert into the full stack
      while (sb.fill < pps_pkg::STACK_DEPTH) begin
        if ($urandom_range(3) == 0)
          issue(pps_pkg::OP_INSERT, pick_kind($urandom_range(1)), pick_type(), 0);
        else issue(pps_pkg::OP_PUSH, pick_kind($urandom_range(1)), pick_type(), 0);
      end
      n = $urandom_range(2, 1);
      repeat (n) begin
        if ($urandom_range(1)) issue(pps_pkg::OP_PUSH, pick_kind(1), pick_type(), 0);
        else issue(pps_pkg::OP_INSERT, pick_kind(0), pick_type(), 0);
      end
      if ($urandom_range(1)) issue(pps_pkg::OP_CLEAR, 0, 0, 0);
      else issue(pps_pkg::OP_POPN, 0, 0, $urandom_range(pps_pkg::STACK_DEPTH, 16));
    end else if (sel < 35) begin
      // terminal buried under non-terminals, then inserts that shift them
      issue(pps_pkg::OP_PUSH, pick_kind(1), pick_type(), 0);
      n = $urandom_range(12);
      repeat (n) issue(pps_pkg::OP_PUSH, pick_kind(0), pick_type(), 0);
      n = $urandom_range(3, 1);
      repeat (n) issue(pps_pkg::OP_INSERT, pick_kind($urandom_range(1)), pick_type(), 0);
    end else if (sel < 58) begin
      n = $urandom_range(6, 1);
      repeat (n) issue(pps_pkg::OP_PUSH, pick_kind($urandom_range(1)), pick_type(), 0);
    end else if (sel < 80) begin
      // reductions: pop amounts at and around the fill level
      case ($urandom_range(4))
        0:       amt = 0;
        1:       amt = sb.fill;
        2:       amt = sb.fill + 1;
        3:       amt = $urandom_range(63);
        default: amt = $urandom_range(sb.fill);
      endcase
      if ($urandom_range(2) == 0)
        issue(pps_pkg::OP_POP, pick_kind($urandom_range(1)), pick_type(), amt);
      else issue(pps_pkg::OP_POPN, pick_kind($urandom_range(1)), pick_type(), amt);
    end else if (sel < 90) begin
      if ($urandom_range(4) == 0)
        issue(pps_pkg::OP_CLEAR, pick_kind(0), pick_type(), $urandom_range(63));
      else issue(pps_pkg::OP_QUERY, pick_kind(1), pick_type(), $urandom_range(63));
    end else begin
      // noise: any bit pattern, unknown operations included
      noise = $urandom;
      send_request(pps_pkg::request_t'(noise[$bits(pps_pkg::request_t)-1:0]));
    end
  endtask

  initial begin : stimulus
    int drain;
    sb  = new();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 77;

    // directed: empty-stack failures, shift through non-terminals, extremes
    issue(pps_pkg::OP_QUERY,  0, 0, 0);
    issue(pps_pkg::OP_POP,    0, 0, 0);      // pop on empty
    issue(pps_pkg::OP_POPN,   0, 0, 0);      // pop n of zero
    issue(pps_pkg::OP_POPN,   0, 0, 1);      // pop n longer than fill
    issue(pps_pkg::OP_INSERT, 5, 1, 0);      // insert, nothing on stack
    issue(pps_pkg::OP_PUSH,  20, 5, 0);
    issue(pps_pkg::OP_INSERT, 6, 2, 0);      // insert, no terminal present
    issue(pps_pkg::OP_QUERY,  0, 0, 0);
    issue(pps_pkg::OP_PUSH,   0, 0, 0);
    issue(pps_pkg::OP_PUSH,  31, 7, 0);
    issue(pps_pkg::OP_PUSH,  int'(pps_pkg::REDUCE_MARK), 4, 0);
    issue(pps_pkg::OP_INSERT, 18, 3, 0);     // shifts two entries
    issue(pps_pkg::OP_QUERY,  31, 7, 63);
    issue(pps_pkg::OP_POPN,   0, 0, 63);     // far too long
    issue(pps_pkg::OP_POPN,   0, 0, 2);
    issue(pps_pkg::OP_POP,    0, 0, 0);
    issue(pps_pkg::OP_PUSH,  18, 7, 0);
    issue(OP_UNUSED_A,       31, 7, 63);     // unknown operations
    issue(OP_UNUSED_B,        0, 0, 0);
    issue(pps_pkg::OP_CLEAR, 31, 7, 63);
    issue(pps_pkg::OP_QUERY,  0, 0, 0);
    issue(pps_pkg::OP_POP,    0, 0, 0);

    // random: phases of idling swap, last one runs flat out
    while (sent < RANDOM_ITEMS) begin
      if (sent >= (2 * RANDOM_ITEMS) / 3) begin
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        phase = 1;
        send_idle_pct = 77;
        recv_idle_pct = 23;
      end
      random_sequence();
    end
    s_tvalid <= 1'b0;

    drain = 0;
    while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
